[hw/rtl/obsc_pkg.sv]
`default_nettype none

package obsc_pkg;

   localparam int VALUE_BITS = 54;

   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic SIDE_BID   = 1'b0;
   localparam logic SIDE_OFFER = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_SWEEP,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

[hw/rtl/order_book_sweep_cost_top.sv]
`default_nettype none

// Two price-level books (bids best-first by descending price, offers by
// ascending price) held in one single-port-read, single-port-write memory,
// with one shared compare, subtract, multiply and accumulate path stepped by
// a small sequencer. A request is taken when start is high and busy is low;
// busy stays high until the result has been shown. The result appears on the
// rsp_ ports for exactly one cycle with rsp_valid high and must be taken then,
// since the block cannot be held off. An add to a full side is rejected;
// otherwise the stored levels that must move up one place to make room
// (none for an empty side) are moved by the memory one level per cycle. A
// query reads nothing when its amount is zero or its side is empty, and
// otherwise reads levels from the best price, one level per cycle through
// the multiply-accumulate pipeline; it reads at most LEVELS levels and at
// most one more than the levels that fill the request. No clearing pass is
// needed after reset.
module order_book_sweep_cost_top #(
   parameter int LEVELS      = 64,
   parameter int PRICE_BITS  = 24,
   parameter int AMOUNT_BITS = 24
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_func,
   input  wire logic                            req_side,
   input  wire logic [PRICE_BITS-1:0]           req_level_price,
   input  wire logic [AMOUNT_BITS-1:0]          req_amount,
   output logic                                 rsp_valid,
   output logic [obsc_pkg::VALUE_BITS-1:0]      rsp_total_value,
   output logic                                 rsp_insufficient,
   output logic                                 rsp_rejected
);

   localparam int IDX_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int CNT_W     = $clog2(LEVELS + 1);
   localparam int ADDR_W    = IDX_W + 1;
   localparam int MEM_DEPTH = 2 << IDX_W;
   localparam int DATA_W    = PRICE_BITS + AMOUNT_BITS;
   localparam int PROD_W    = PRICE_BITS + AMOUNT_BITS;
   localparam int SUM_W     =
      ((PROD_W > obsc_pkg::VALUE_BITS) ? PROD_W : obsc_pkg::VALUE_BITS) + 1;
   localparam logic [SUM_W-1:0] VALUE_MAX =
      {{(SUM_W - obsc_pkg::VALUE_BITS){1'b0}}, {obsc_pkg::VALUE_BITS{1'b1}}};

   // level memory: word is {price, amount}, address is {side, index}
   logic [DATA_W-1:0] mem [MEM_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic              we;
   logic [ADDR_W-1:0] wa;
   logic [ADDR_W-1:0] ra;
   logic [DATA_W-1:0] wd;

   obsc_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]       bid_cnt_ff, bid_cnt_in;
   logic [CNT_W-1:0]       offer_cnt_ff, offer_cnt_in;
   logic                   v1_ff, v1_in;
   logic                   v2_ff, v2_in;
   logic                   v3_ff, v3_in;

   logic                   func_ff, func_in;
   logic                   side_ff, side_in;
   logic [PRICE_BITS-1:0]  price_ff, price_in;
   logic [AMOUNT_BITS-1:0] amt_ff, amt_in;
   logic [AMOUNT_BITS-1:0] rem_ff, rem_in;
   logic [IDX_W-1:0]       hole_ff, hole_in;
   logic [CNT_W-1:0]       iss_ff, iss_in;
   logic [AMOUNT_BITS-1:0] take_ff, take_in;
   logic [PRICE_BITS-1:0]  pr1_ff, pr1_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [obsc_pkg::VALUE_BITS-1:0] sum_ff, sum_in;
   logic                   rej_ff, rej_in;

   logic [CNT_W-1:0]       cnt_req;
   logic [CNT_W-1:0]       cnt_req_dec;
   logic [CNT_W-1:0]       cnt_side;
   logic [PRICE_BITS-1:0]  ent_price;
   logic [AMOUNT_BITS-1:0] ent_amt;
   logic                   move;
   logic                   issue;
   logic [SUM_W-1:0]       sum_wide;
   logic                   short_fill;

   assign cnt_req     = (req_side == obsc_pkg::SIDE_OFFER) ? offer_cnt_ff : bid_cnt_ff;
   assign cnt_req_dec = cnt_req - CNT_W'(1);
   assign cnt_side    = (side_ff == obsc_pkg::SIDE_OFFER) ? offer_cnt_ff : bid_cnt_ff;
   assign ent_price   = rd_data_ff[DATA_W-1 -: PRICE_BITS];
   assign ent_amt     = rd_data_ff[AMOUNT_BITS-1:0];
   assign move        = (side_ff == obsc_pkg::SIDE_OFFER) ? (ent_price > price_ff)
                                                          : (ent_price < price_ff);
   assign issue       = (iss_ff != cnt_side) && (rem_ff != '0);
   assign sum_wide    = SUM_W'(sum_ff) + SUM_W'(prod_ff);
   assign short_fill  = (func_ff == obsc_pkg::FUNC_QUERY) && (rem_ff != '0);

   assign busy             = (state_ff != obsc_pkg::ST_IDLE);
   assign rsp_valid        = (state_ff == obsc_pkg::ST_RESP);
   assign rsp_insufficient = rsp_valid && short_fill;
   assign rsp_rejected     = rsp_valid && rej_ff;
   assign rsp_total_value  = (rsp_valid && !short_fill) ? sum_ff : '0;

   always_comb begin
      state_in     = state_ff;
      bid_cnt_in   = bid_cnt_ff;
      offer_cnt_in = offer_cnt_ff;
      v1_in        = 1'b0;
      v2_in        = 1'b0;
      v3_in        = 1'b0;
      func_in      = func_ff;
      side_in      = side_ff;
      price_in     = price_ff;
      amt_in       = amt_ff;
      rem_in       = rem_ff;
      hole_in      = hole_ff;
      iss_in       = iss_ff;
      take_in      = take_ff;
      pr1_in       = pr1_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      rej_in       = rej_ff;
      we           = 1'b0;
      wa           = {side_ff, hole_ff};
      wd           = {price_ff, amt_ff};
      ra           = {side_ff, iss_ff[IDX_W-1:0]};

      unique case (state_ff)
         obsc_pkg::ST_IDLE: begin
            // prefetch the last stored level for an add
            ra = {req_side, cnt_req_dec[IDX_W-1:0]};
            if (start) begin
               func_in  = req_func;
               side_in  = req_side;
               price_in = req_level_price;
               amt_in   = req_amount;
               rem_in   = req_amount;
               sum_in   = '0;
               rej_in   = 1'b0;
               iss_in   = '0;
               hole_in  = cnt_req[IDX_W-1:0];
               if (req_func == obsc_pkg::FUNC_QUERY) begin
                  state_in = obsc_pkg::ST_SWEEP;
               end else if (cnt_req == CNT_W'(LEVELS)) begin
                  rej_in   = 1'b1;
                  state_in = obsc_pkg::ST_RESP;
               end else if (cnt_req == '0) begin
                  state_in = obsc_pkg::ST_INS_PUT;
               end else begin
                  state_in = obsc_pkg::ST_INS_CMP;
               end
            end
         end

         obsc_pkg::ST_INS_CMP: begin
            we = 1'b1;
            if (move) begin
               wd      = rd_data_ff;
               hole_in = hole_ff - IDX_W'(1);
               ra      = {side_ff, hole_ff - IDX_W'(2)};
               if (hole_ff == IDX_W'(1)) begin
                  state_in = obsc_pkg::ST_INS_PUT;
               end
            end else begin
               if (side_ff == obsc_pkg::SIDE_OFFER) begin
                  offer_cnt_in = offer_cnt_ff + CNT_W'(1);
               end else begin
                  bid_cnt_in = bid_cnt_ff + CNT_W'(1);
               end
               state_in = obsc_pkg::ST_RESP;
            end
         end

         obsc_pkg::ST_INS_PUT: begin
            we = 1'b1;
            if (side_ff == obsc_pkg::SIDE_OFFER) begin
               offer_cnt_in = offer_cnt_ff + CNT_W'(1);
            end else begin
               bid_cnt_in = bid_cnt_ff + CNT_W'(1);
            end
            state_in = obsc_pkg::ST_RESP;
         end

         obsc_pkg::ST_SWEEP: begin
            v1_in = issue;
            v2_in = v1_ff;
            v3_in = v2_ff;
            if (issue) begin
               iss_in = iss_ff + CNT_W'(1);
            end
            // take the smaller of what is left and the level amount
            if (v1_ff) begin
               pr1_in = ent_price;
               if (rem_ff > ent_amt) begin
                  take_in = ent_amt;
                  rem_in  = rem_ff - ent_amt;
               end else begin
                  take_in = rem_ff;
                  rem_in  = '0;
               end
            end
            if (v2_ff) begin
               prod_in = PROD_W'(take_ff) * PROD_W'(pr1_ff);
            end
            if (v3_ff) begin
               if (sum_wide > VALUE_MAX) begin
                  sum_in = {obsc_pkg::VALUE_BITS{1'b1}};
               end else begin
                  sum_in = sum_wide[obsc_pkg::VALUE_BITS-1:0];
               end
            end
            if (!issue && !v1_ff && !v2_ff && !v3_ff) begin
               state_in = obsc_pkg::ST_RESP;
            end
         end

         obsc_pkg::ST_RESP: begin
            state_in = obsc_pkg::ST_IDLE;
         end

         default: begin
            state_in = obsc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= obsc_pkg::ST_IDLE;
         bid_cnt_ff   <= '0;
         offer_cnt_ff <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bid_cnt_ff   <= bid_cnt_in;
         offer_cnt_ff <= offer_cnt_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      side_ff  <= side_in;
      price_ff <= price_in;
      amt_ff   <= amt_in;
      rem_ff   <= rem_in;
      hole_ff  <= hole_in;
      iss_ff   <= iss_in;
      take_ff  <= take_in;
      pr1_ff   <= pr1_in;
      prod_ff  <= prod_in;
      sum_ff   <= sum_in;
      rej_ff   <= rej_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_data_ff <= mem[ra];
   end

endmodule

`default_nettype wire
